// File: src/rfsp_pkg.sv
// Shared types, codes and constants for the rotated frame scan-out packer.
// No dependencies; rfsp_front, rfsp_back and the top level import this package.
package rfsp_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 17;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;

  localparam int unsigned DEF_PANEL_WIDTH  = 640;
  localparam int unsigned DEF_PANEL_HEIGHT = 384;
  localparam int unsigned DEF_STORE_BYTES  = 131072;

  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH = 2;

  // panel nibble for a set pixel at 1 bpp
  localparam logic [NIB_W-1:0] MONO_ON_NIBBLE = 4'h3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_FETCH   = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_FETCH   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_2BPP = 2'd1,
    DEPTH_4BPP = 2'd2
  } depth_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PIXEL_DEPTH = 3'd0,
    REG_ROTATION    = 3'd1,
    REG_PALETTE_0   = 3'd2,
    REG_PALETTE_1   = 3'd3,
    REG_PALETTE_2   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] store_address;
    logic [DATA_W-1:0] store_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] panel_byte;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       pixel_depth;
    logic [1:0]       rotation;
    logic [NIB_W-1:0] palette_0;
    logic [NIB_W-1:0] palette_1;
    logic [NIB_W-1:0] palette_2;
  } cfg_t;

endpackage

// File: src/rfsp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rfsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rfsp_fifo.sv
// Small register-based FIFO used for the command and result queues.
// No dependencies.
module rfsp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  always_comb begin
    full_o   = (count_q == CW'(DEPTH));
    empty_o  = (count_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];

`ifndef SYNTH
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fifo count did not follow a lone push");
`endif

endmodule

// File: src/rfsp_front.sv
// Front end: accepts input items, classifies them by opcode and queues commands.
// Depends on rfsp_pkg and rfsp_fifo.
module rfsp_front import rfsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  output cmd_t     cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i
);

  cmd_t cmd;
  logic keep;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd.kind = CMD_WRITE;
    cmd.addr = item_i.store_address;
    cmd.data = item_i.store_data;
    keep     = 1'b0;
    unique case (item_i.opcode)
      OP_WRITE: begin
        cmd.kind = CMD_WRITE;
        keep     = 1'b1;
      end
      OP_FETCH: begin
        cmd.kind = CMD_FETCH;
        keep     = 1'b1;
      end
      OP_RESTART: begin
        cmd.kind = CMD_RESTART;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  rfsp_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && keep),
    .wdata_i(cmd),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

// File: src/rfsp_back.sv
// Back end: scan position, rotation mapping, frame store access and pixel packing.
// Depends on rfsp_pkg and rfsp_ram.
module rfsp_back import rfsp_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT,
  parameter int unsigned STORE_BYTES  = DEF_STORE_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  output out_item_t res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);

  localparam int unsigned MAXDIM = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int unsigned CW     = $clog2(MAXDIM);
  localparam int unsigned BW_W   = CW + 1;
  localparam int unsigned PRODW  = CW + BW_W;
  localparam int unsigned PAIRS  = PANEL_WIDTH / 2;
  localparam int unsigned RW     = $clog2(PANEL_HEIGHT);
  localparam int unsigned PRW    = $clog2(PAIRS);
  localparam int unsigned NPIX   = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned IW     = $clog2(NPIX);
  localparam int unsigned AW     = $clog2(STORE_BYTES);

  // scan position
  logic [RW-1:0]  row_q, row_d;
  logic [PRW-1:0] pair_q, pair_d;
  logic           half_q, half_d;

  // issue
  logic            adv, issue, last;
  logic [CW-1:0]   col, row, x, y;
  logic [BW_W-1:0] bw;

  // address stage
  logic              s1_v_q, s1_v_d;
  logic              s1_write_q, s1_write_d;
  logic              s1_half_q, s1_half_d;
  logic              s1_last_q, s1_last_d;
  logic [PRODW-1:0]  s1_prod_q, s1_prod_d;
  logic [CW-1:0]     s1_x_q, s1_x_d;
  logic [ADDR_W-1:0] s1_addr_q, s1_addr_d;
  logic [DATA_W-1:0] s1_data_q, s1_data_d;
  logic [IW-1:0]     idx, pos;
  logic [2:0]        sh;
  logic              in_store, wr_in_store;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  // extract stage
  logic              s2_v_q, s2_v_d;
  logic              s2_half_q, s2_half_d;
  logic              s2_last_q, s2_last_d;
  logic              s2_zero_q, s2_zero_d;
  logic [2:0]        s2_sh_q, s2_sh_d;
  logic [NIB_W-1:0]  hi_q;
  logic [DATA_W-1:0] shifted;
  logic [NIB_W-1:0]  pix, nib;

  assign adv   = !(s2_v_q && s2_half_q && res_full_i);
  assign issue = adv && cmd_valid_i;
  assign last  = (row_q == RW'(PANEL_HEIGHT - 1)) && (pair_q == PRW'(PAIRS - 1));

  always_comb begin
    cmd_pop_o = 1'b0;
    row_d     = row_q;
    pair_d    = pair_q;
    half_d    = half_q;
    s1_v_d    = s1_v_q;
    if (adv) begin
      s1_v_d = 1'b0;
    end
    if (issue) begin
      case (cmd_i.kind)
        CMD_WRITE: begin
          cmd_pop_o = 1'b1;
          s1_v_d    = 1'b1;
        end
        CMD_FETCH: begin
          s1_v_d    = 1'b1;
          half_d    = !half_q;
          cmd_pop_o = half_q;
          if (half_q) begin
            if (pair_q == PRW'(PAIRS - 1)) begin
              pair_d = '0;
              row_d  = (row_q == RW'(PANEL_HEIGHT - 1)) ? '0 : row_q + 1'b1;
            end else begin
              pair_d = pair_q + 1'b1;
            end
          end
        end
        CMD_RESTART: begin
          cmd_pop_o = 1'b1;
          row_d     = '0;
          pair_d    = '0;
          half_d    = 1'b0;
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    col = CW'({pair_q, half_q});
    row = CW'(row_q);
    bw  = cfg_i.rotation[0] ? BW_W'(PANEL_HEIGHT) : BW_W'(PANEL_WIDTH);
    case (cfg_i.rotation)
      ROT_0: begin
        x = col;
        y = row;
      end
      ROT_90: begin
        x = CW'(PANEL_HEIGHT - 1) - row;
        y = col;
      end
      ROT_180: begin
        x = CW'(PANEL_WIDTH - 1) - col;
        y = CW'(PANEL_HEIGHT - 1) - row;
      end
      default: begin
        x = row;
        y = CW'(PANEL_WIDTH - 1) - col;
      end
    endcase
    s1_write_d = (cmd_i.kind == CMD_WRITE);
    s1_half_d  = half_q;
    s1_last_d  = last;
    s1_prod_d  = PRODW'(y) * PRODW'(bw);
    s1_x_d     = x;
    s1_addr_d  = cmd_i.addr;
    s1_data_d  = cmd_i.data;
  end

  always_comb begin
    idx = IW'(s1_prod_q + PRODW'(s1_x_q));
    case (cfg_i.pixel_depth)
      DEPTH_1BPP: begin
        pos = idx >> 3;
        sh  = s1_x_q[2:0];
      end
      DEPTH_2BPP: begin
        pos = idx >> 2;
        sh  = {s1_x_q[1:0], 1'b0};
      end
      default: begin
        pos = idx >> 1;
        sh  = {s1_x_q[0], 2'b00};
      end
    endcase
    in_store    = 32'(pos) < 32'(STORE_BYTES);
    wr_in_store = 32'(s1_addr_q) < 32'(STORE_BYTES);
    ram_we      = adv && s1_v_q && s1_write_q && wr_in_store;
    ram_re      = adv && s1_v_q && !s1_write_q && in_store;
    ram_addr    = s1_write_q ? AW'(s1_addr_q) : AW'(pos);
    s2_v_d      = adv ? (s1_v_q && !s1_write_q) : s2_v_q;
    s2_half_d   = s1_half_q;
    s2_last_d   = s1_last_q;
    s2_zero_d   = !in_store;
    s2_sh_d     = sh;
  end

  rfsp_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_BYTES)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(s1_data_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    shifted = ram_rdata >> s2_sh_q;
    case (cfg_i.pixel_depth)
      DEPTH_1BPP: pix = {3'b000, shifted[0]};
      DEPTH_2BPP: pix = {2'b00, shifted[1:0]};
      default:    pix = shifted[3:0];
    endcase
    if (s2_zero_q) begin
      pix = '0;
    end
    if (cfg_i.pixel_depth == DEPTH_1BPP) begin
      nib = (pix == NIB_W'(1)) ? MONO_ON_NIBBLE : '0;
    end else begin
      case (pix)
        4'd0:    nib = cfg_i.palette_0;
        4'd1:    nib = cfg_i.palette_1;
        4'd2:    nib = cfg_i.palette_2;
        default: nib = '0;
      endcase
    end
    res_o.panel_byte = {hi_q, nib};
    res_o.frame_end  = s2_last_q;
    res_push_o       = s2_v_q && s2_half_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      pair_q <= '0;
      half_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      pair_q <= pair_d;
      half_q <= half_d;
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_write_q <= s1_write_d;
      s1_half_q  <= s1_half_d;
      s1_last_q  <= s1_last_d;
      s1_prod_q  <= s1_prod_d;
      s1_x_q     <= s1_x_d;
      s1_addr_q  <= s1_addr_d;
      s1_data_q  <= s1_data_d;
    end
    if (adv) begin
      s2_half_q <= s2_half_d;
      s2_last_q <= s2_last_d;
      s2_zero_q <= s2_zero_d;
      s2_sh_q   <= s2_sh_d;
    end
    if (adv && s2_v_q && !s2_half_q) begin
      hi_q <= nib;
    end
  end

`ifndef SYNTH
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("frame store read and write in one cycle");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !adv) |=> (s2_v_q && s2_half_q && $stable(s2_last_q) && $stable(hi_q)))
    else $error("stalled result not held");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && cmd_i.kind == CMD_FETCH && half_q && last) |=> (row_q == '0 && pair_q == '0))
    else $error("scan position did not wrap after frame end");
`endif

endmodule

// File: src/rotated_frame_scanout_packer.sv
// Top level of the rotated frame scan-out packer: configuration registers,
// front end, back end and result queue. Depends on rfsp_pkg, rfsp_front,
// rfsp_back and rfsp_fifo.
//
// Items enter through a queue-style port (push/full) and results leave through
// another (empty/pop). A fetch makes one frame-store read per panel pixel
// through the single-port RAM, and its panel byte passes the address and
// extract stages before it enters the result queue. The frame store has no
// reset: read back only bytes written earlier. Opcode 3 is accepted and dropped.
// Configuration is an APB-style port with registers at byte addresses 0, 4, 8,
// 12 and 16 (pixel depth, rotation, palette entries 0 to 2); write it only while
// no fetch is in flight.
module rotated_frame_scanout_packer import rfsp_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT,
  parameter int unsigned STORE_BYTES  = DEF_STORE_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item_i,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg_q, cfg_d;
  logic      cfg_we;
  reg_idx_e  reg_idx;
  cmd_t      cmd;
  logic      cmd_valid, cmd_pop;
  out_item_t res;
  logic      res_push, res_full;
  logic [$bits(out_item_t)-1:0] res_rdata;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (reg_idx)
        REG_PIXEL_DEPTH: cfg_d.pixel_depth = pwdata[1:0];
        REG_ROTATION:    cfg_d.rotation    = pwdata[1:0];
        REG_PALETTE_0:   cfg_d.palette_0   = pwdata[NIB_W-1:0];
        REG_PALETTE_1:   cfg_d.palette_1   = pwdata[NIB_W-1:0];
        REG_PALETTE_2:   cfg_d.palette_2   = pwdata[NIB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_DEPTH: prdata = PDATA_W'(cfg_q.pixel_depth);
      REG_ROTATION:    prdata = PDATA_W'(cfg_q.rotation);
      REG_PALETTE_0:   prdata = PDATA_W'(cfg_q.palette_0);
      REG_PALETTE_1:   prdata = PDATA_W'(cfg_q.palette_1);
      REG_PALETTE_2:   prdata = PDATA_W'(cfg_q.palette_2);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  rfsp_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  rfsp_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign out_item_o = out_item_t'(res_rdata);

endmodule
